// ===== design/lps_pkg.sv =====
`default_nettype none
package lps_pkg;
  localparam int TABLE_SIZE_DEF = 64;
  localparam int TOTAL_W = 22;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0, OP_SET_TICKETS = 3'd1, OP_KILL = 3'd2,
    OP_DRAW = 3'd3, OP_SET_STATE = 3'd4, OP_READ = 3'd5
  } op_e;

  localparam logic [2:0] ST_UNUSED   = 3'd0;
  localparam logic [2:0] ST_EMBRYO   = 3'd1;
  localparam logic [2:0] ST_SLEEPING = 3'd2;
  localparam logic [2:0] ST_RUNNABLE = 3'd3;
  localparam logic [2:0] ST_RUNNING  = 3'd4;
  localparam logic [2:0] ST_LAST     = 3'd5;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_FULL      = 3'd1;
  localparam logic [2:0] STAT_BAD_TICK  = 3'd2;
  localparam logic [2:0] STAT_NO_PID    = 3'd3;
  localparam logic [2:0] STAT_NO_WINNER = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  slot;
    logic [15:0] target_pid;
    logic [15:0] ticket_value;
    logic [21:0] draw_value;
    logic [2:0]  new_state;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  out_slot;
    logic [15:0] out_pid;
    logic [15:0] out_tickets;
    logic [31:0] out_runs;
    logic [2:0]  out_state;
    logic        out_killed;
    logic [21:0] ticket_total;
  } result_t;

  typedef struct packed {
    logic [2:0]  state;
    logic [15:0] pid;
    logic [15:0] tickets;
    logic [31:0] runs;
    logic        killed;
  } entry_t;

  // token accumulated at the head cell while the ring of cells rotates during a scan
  typedef struct packed {
    logic        found;
    logic [21:0] sum;
  } scan_t;
endpackage
`default_nettype wire

// ===== design/lps_cell.sv =====
`default_nettype none
module lps_cell import lps_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   shift,
  input  wire entry_t entry_in,
  input  wire logic   load,
  input  wire entry_t load_val,
  output entry_t      entry
);
  // entries rotate one place per shift; load takes priority over shift
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (load) begin
      entry <= load_val;
    end else if (shift) begin
      entry <= entry_in;
    end
  end
endmodule
`default_nettype wire

// ===== design/lottery_process_scheduler_unit.sv =====
// Lottery scheduler task table. Each command is taken when start is high and
// busy is low; its result appears for one cycle with done. Every command
// rotates the whole table once through a ring of TABLE_SIZE cells, one entry
// per cycle. busy is already low while done is high, so the next command may
// be taken at the edge that ends the done cycle. The result cannot be stalled.
`default_nettype none
module lottery_process_scheduler_unit import lps_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire cmd_t cmd,
  output logic      busy,
  output logic      done,
  output result_t   result
);
  localparam int IW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);

  entry_t cells [TABLE_SIZE];
  logic   shift;
  logic   load;
  entry_t load_val;

  for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_cell
    lps_cell u_cell (
      .clk, .rst, .shift,
      .entry_in(cells[(g + 1) % TABLE_SIZE]),
      .load(load && g == TABLE_SIZE - 1),
      .load_val,
      .entry(cells[g])
    );
  end

  cmd_t        c;
  logic [CW-1:0] cnt;
  logic [21:0] total;
  logic [15:0] next_id;
  logic [IW-1:0] cur;
  logic        cur_valid;
  scan_t       tok;
  logic [IW-1:0] hit_slot;
  entry_t      hit_entry;

  // head entry cells[0] has slot index cnt
  entry_t h;
  logic [IW-1:0] idx;
  logic        match;
  logic [21:0] sum_n;
  assign h     = cells[0];
  assign idx   = cnt[IW-1:0];
  assign sum_n = tok.sum + 22'(h.tickets);

  always_comb begin
    match = 1'b0;
    load_val = h;
    unique case (c.op) inside
      OP_ALLOC: match = h.state == ST_UNUSED;
      OP_SET_TICKETS: match = cur_valid && idx == cur && c.ticket_value != 16'd0;
      OP_KILL: match = h.state != ST_UNUSED && h.pid == c.target_pid;
      OP_DRAW: match = h.state == ST_RUNNABLE && sum_n > c.draw_value;
      OP_SET_STATE, OP_READ: match = 32'(c.slot) < TABLE_SIZE && 6'(idx) == c.slot;
      default: match = 1'b0;
    endcase
    match = match && !tok.found;
    unique case (c.op)
      OP_ALLOC: begin
        load_val = '{state: ST_EMBRYO, pid: next_id, tickets: 16'd1, runs: 32'd0,
                     killed: 1'b0};
      end
      OP_SET_TICKETS: load_val.tickets = c.ticket_value;
      OP_KILL: begin
        load_val.killed = 1'b1;
        if (h.state == ST_SLEEPING) load_val.state = ST_RUNNABLE;
        load_val.tickets = '0;
        load_val.runs = '0;
      end
      OP_DRAW: begin
        load_val.state = ST_RUNNING;
        load_val.runs = h.runs + 32'd1;
      end
      OP_SET_STATE: begin
        if (c.new_state <= ST_LAST) begin
          load_val.state = c.new_state;
          if (c.new_state == ST_UNUSED) begin
            load_val.pid = '0;
            load_val.killed = 1'b0;
          end
        end
      end
      default: load_val = h;
    endcase
  end
  assign load = busy && match;
  assign shift = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0; cnt <= '0; total <= '0; next_id <= 16'd1;
      cur <= '0; cur_valid <= 1'b0; tok <= '0;
    end else begin
      done <= busy && (cnt == CW'(TABLE_SIZE - 1));
      if (start && !busy) begin
        c <= cmd; busy <= 1'b1; cnt <= '0; tok <= '0;
      end else if (busy) begin
        if (!tok.found) begin
          tok <= '{found: match, sum: (h.state == ST_RUNNABLE) ? sum_n : tok.sum};
        end
        if (match) begin
          hit_slot <= idx;
          hit_entry <= load_val;
          unique case (c.op)
            OP_ALLOC: begin
              total <= total - 22'(h.tickets) + 22'd1;
              next_id <= next_id + 16'd1;
            end
            OP_SET_TICKETS: total <= total - 22'(h.tickets) + 22'(c.ticket_value);
            OP_KILL: total <= total - 22'(h.tickets);
            OP_DRAW: begin cur <= idx; cur_valid <= 1'b1; end
            default: ;
          endcase
        end
        if (cnt == CW'(TABLE_SIZE - 1)) begin
          busy <= 1'b0;
        end
        cnt <= cnt + CW'(1);
      end
    end
  end

  always_comb begin
    result = '0;
    result.ticket_total = total;
    if (c.op == OP_SET_TICKETS && cur_valid && c.ticket_value == 16'd0)
      result.status = STAT_BAD_TICK;
    else if (c.op <= OP_READ && !tok.found) begin
      unique case (c.op)
        OP_ALLOC: result.status = STAT_FULL;
        OP_DRAW: result.status = STAT_NO_WINNER;
        default: result.status = STAT_NO_PID;
      endcase
    end else if (c.op <= OP_READ) begin
      result.out_slot = 6'(hit_slot);
      result.out_pid = hit_entry.pid;
      result.out_tickets = hit_entry.tickets;
      result.out_runs = hit_entry.runs;
      result.out_state = hit_entry.state;
      result.out_killed = hit_entry.killed;
    end
  end
endmodule
`default_nettype wire

// ===== design/lps_checker.sv =====
`default_nettype none
module lps_checker import lps_pkg::*; (
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire logic    busy,
  input wire logic    done,
  input wire result_t result
);
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted transaction not busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != STAT_OK |-> result.out_pid == 16'd0 && result.out_runs == 32'd0)
    else $error("error result carries entry data");
endmodule
bind lottery_process_scheduler_unit lps_checker u_chk (.*);
`default_nettype wire
